>>> design/cb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cb_pkg - shared types, constants and scan functions of the comment blanker
// Holds the configuration and scan-state structs, the code constants and the
// one-byte scan step used by the core.
// ============================================================================
package cb_pkg;

   // Window depth and nesting counter width
   localparam int MAX_MARKER      = 4;
   localparam int NEST_BITS       = 8;
   localparam int MARKER_REG_BITS = 32;
   localparam int LEN_BITS        = 3;
   localparam int FILL_W          = $clog2(MAX_MARKER + 1);
   localparam int IDX_W           = (MAX_MARKER > 1) ? $clog2(MAX_MARKER) : 1;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam logic [NEST_BITS-1:0] NEST_MAX = '1;

   // Character codes
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_LINE_MARKER      = 3'd0,
      REG_LINE_MARKER_LEN  = 3'd1,
      REG_BEGIN_MARKER     = 3'd2,
      REG_BEGIN_MARKER_LEN = 3'd3,
      REG_END_MARKER       = 3'd4,
      REG_END_MARKER_LEN   = 3'd5,
      REG_TRACK_QUOTES     = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_mode_type;

   typedef struct packed {
      logic [MARKER_REG_BITS-1:0] line_marker;
      logic [LEN_BITS-1:0]        line_marker_len;
      logic [MARKER_REG_BITS-1:0] begin_marker;
      logic [LEN_BITS-1:0]        begin_marker_len;
      logic [MARKER_REG_BITS-1:0] end_marker;
      logic [LEN_BITS-1:0]        end_marker_len;
      logic                       track_quotes;
   } cfg_type;

   typedef struct packed {
      logic [MAX_MARKER-1:0][7:0] window;
      logic [FILL_W-1:0]          fill;
      logic [NEST_BITS-1:0]       nest_depth;
      quote_mode_type             quote_mode;
      logic                       in_line_comment;
      logic [FILL_W-1:0]          forced_bytes;
      logic                       forced_blank;
      logic [7:0]                 prior_out;
   } scan_state_type;

   typedef struct packed {
      scan_state_type st;
      logic [7:0]     out_byte;
   } emit_result_type;

   // Core status seen by the top-level checks
   typedef struct packed {
      logic              draining;
      logic              take;
      logic [FILL_W-1:0] fill;
   } core_status_type;

   // Clamp a marker length to the window depth
   function automatic logic [FILL_W-1:0] eff_len(logic [LEN_BITS-1:0] len);
      logic [FILL_W-1:0] r;
      if (int'(len) > MAX_MARKER) begin
         r = FILL_W'(MAX_MARKER);
      end else begin
         r = FILL_W'(len);
      end
      return r;
   endfunction

   // Shift-JIS double-byte lead
   function automatic logic is_lead(logic [7:0] b);
      return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
   endfunction

   // Compare the head of the window with a marker; bytes past the register read zero
   function automatic logic marker_match(logic [MAX_MARKER-1:0][7:0] window,
                                         logic [MARKER_REG_BITS-1:0] marker,
                                         logic [FILL_W-1:0] len,
                                         logic [FILL_W-1:0] avail);
      logic ok;
      ok = (len != '0) && (len <= avail);
      for (int i = 0; i < MAX_MARKER; i++) begin
         if ((i < int'(len)) && (window[i] != 8'(marker >> (8 * i)))) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // One output byte from the head of the window, with the state it leaves
   function automatic emit_result_type emit_head(scan_state_type st, cfg_type cfg,
                                                 logic last);
      emit_result_type   r;
      logic [7:0]        b;
      logic [FILL_W-1:0] bl;
      logic [FILL_W-1:0] el;
      logic [FILL_W-1:0] ll;
      logic              beg_hit;
      logic              end_hit;
      logic              line_hit;
      r          = '{st: st, out_byte: st.window[0]};
      b          = st.window[0];
      bl         = eff_len(cfg.begin_marker_len);
      el         = eff_len(cfg.end_marker_len);
      ll         = eff_len(cfg.line_marker_len);
      beg_hit    = (bl != '0) && marker_match(st.window, cfg.begin_marker, bl, st.fill);
      end_hit    = (bl != '0) && marker_match(st.window, cfg.end_marker, el, st.fill);
      line_hit   = marker_match(st.window, cfg.line_marker, ll, st.fill);

      if (st.forced_bytes != '0) begin
         // tail of a marker or double byte taken whole
         r.out_byte        = st.forced_blank ? CH_SPACE : b;
         r.st.forced_bytes = st.forced_bytes - 1'b1;
      end else if (st.in_line_comment) begin
         r.out_byte = (b == CH_TAB) ? b : CH_SPACE;
      end else if ((st.nest_depth != '0) && (st.quote_mode == QUOTE_NONE)) begin
         // inside a block comment
         r.out_byte = CH_SPACE;
         if (is_lead(b)) begin
            if (!last) begin
               r.st.forced_bytes = FILL_W'(1);
               r.st.forced_blank = 1'b1;
            end
         end else if (beg_hit) begin
            r.st.forced_bytes = bl - 1'b1;
            r.st.forced_blank = 1'b1;
            if (st.nest_depth != NEST_MAX) begin
               r.st.nest_depth = st.nest_depth + 1'b1;
            end
         end else if (end_hit) begin
            r.st.forced_bytes = el - 1'b1;
            r.st.forced_blank = 1'b1;
            r.st.nest_depth   = st.nest_depth - 1'b1;
         end else if (b == CH_TAB) begin
            r.out_byte = b;
         end
      end else if (is_lead(b)) begin
         if (!last) begin
            r.st.forced_bytes = FILL_W'(1);
            r.st.forced_blank = 1'b0;
         end
      end else if ((st.quote_mode == QUOTE_NONE) && beg_hit) begin
         r.out_byte        = CH_SPACE;
         r.st.forced_bytes = bl - 1'b1;
         r.st.forced_blank = 1'b1;
         if (st.nest_depth != NEST_MAX) begin
            r.st.nest_depth = st.nest_depth + 1'b1;
         end
      end else if ((st.quote_mode == QUOTE_NONE) && line_hit) begin
         r.st.in_line_comment = 1'b1;
         r.out_byte           = (b == CH_TAB) ? b : CH_SPACE;
      end else if (cfg.track_quotes && (st.prior_out != CH_BSLASH)) begin
         // toggle quote state unless escaped
         if (b == CH_SQUOTE) begin
            if (st.quote_mode == QUOTE_NONE) begin
               r.st.quote_mode = QUOTE_SINGLE;
            end else if (st.quote_mode == QUOTE_SINGLE) begin
               r.st.quote_mode = QUOTE_NONE;
            end
         end else if (b == CH_DQUOTE) begin
            if (st.quote_mode == QUOTE_NONE) begin
               r.st.quote_mode = QUOTE_DOUBLE;
            end else if (st.quote_mode == QUOTE_DOUBLE) begin
               r.st.quote_mode = QUOTE_NONE;
            end
         end
      end

      // advance the window
      r.st.prior_out = r.out_byte;
      for (int i = 0; i < MAX_MARKER - 1; i++) begin
         r.st.window[i] = st.window[i + 1];
      end
      if (st.fill != '0) begin
         r.st.fill = st.fill - 1'b1;
      end
      return r;
   endfunction

endpackage

>>> design/cb_req_if.sv
`timescale 1ns / 1ps
// ============================================================================
// cb_req_if - input channel of the comment blanker
// Carries one source byte per item with its line-end mark.
// ============================================================================
interface cb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       line_end;

   modport source (output valid, output text_byte, output line_end, input ready);
   modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

>>> design/cb_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// cb_rsp_if - result channel of the comment blanker
// Carries one output byte per item with its line-end and run-end marks.
// ============================================================================
interface cb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_line_end;
   logic       last_of_run;

   modport source (output valid, output out_byte, output out_line_end,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input out_line_end,
                   input last_of_run, output ready);
endinterface

>>> design/cb_csr.sv
`timescale 1ns / 1ps
// ============================================================================
// cb_csr - configuration registers of the comment blanker
// APB-style register file: marker bytes, marker lengths and quote tracking.
// ============================================================================
module cb_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                           csr_pready,
   output cb_pkg::cfg_type                cfg
);

   cb_pkg::cfg_type       cfg_ff;
   cb_pkg::cfg_type       cfg_in;
   cb_pkg::reg_index_type index;
   logic                  wr_en;

   assign index      = cb_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            cb_pkg::REG_LINE_MARKER:      cfg_in.line_marker      = csr_pwdata;
            cb_pkg::REG_LINE_MARKER_LEN:  cfg_in.line_marker_len  = csr_pwdata[2:0];
            cb_pkg::REG_BEGIN_MARKER:     cfg_in.begin_marker     = csr_pwdata;
            cb_pkg::REG_BEGIN_MARKER_LEN: cfg_in.begin_marker_len = csr_pwdata[2:0];
            cb_pkg::REG_END_MARKER:       cfg_in.end_marker       = csr_pwdata;
            cb_pkg::REG_END_MARKER_LEN:   cfg_in.end_marker_len   = csr_pwdata[2:0];
            cb_pkg::REG_TRACK_QUOTES:     cfg_in.track_quotes     = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (index)
         cb_pkg::REG_LINE_MARKER:      csr_prdata = cfg_ff.line_marker;
         cb_pkg::REG_LINE_MARKER_LEN:  csr_prdata = 32'(cfg_ff.line_marker_len);
         cb_pkg::REG_BEGIN_MARKER:     csr_prdata = cfg_ff.begin_marker;
         cb_pkg::REG_BEGIN_MARKER_LEN: csr_prdata = 32'(cfg_ff.begin_marker_len);
         cb_pkg::REG_END_MARKER:       csr_prdata = cfg_ff.end_marker;
         cb_pkg::REG_END_MARKER_LEN:   csr_prdata = 32'(cfg_ff.end_marker_len);
         cb_pkg::REG_TRACK_QUOTES:     csr_prdata = 32'(cfg_ff.track_quotes);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/cb_core.sv
`timescale 1ns / 1ps
// ============================================================================
// cb_core - scan engine of the comment blanker
// Input register, lookahead window with scan state, one-byte scan step and
// result register. Line ends drain the window one result per unstalled cycle.
// ============================================================================
module cb_core (
   input  logic                    clock,
   input  logic                    reset,
   input  cb_pkg::cfg_type         cfg,
   cb_req_if.sink                  req_ch,
   cb_rsp_if.source                rsp_ch,
   output cb_pkg::core_status_type status
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // scan state
   cb_pkg::scan_state_type st_ff, st_in;
   logic                   drain_ff, drain_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;
   logic       out_last_ff, out_last_in;

   cb_pkg::scan_state_type  appended;
   cb_pkg::scan_state_type  src;
   cb_pkg::emit_result_type em;
   logic [cb_pkg::FILL_W-1:0] slot;
   logic                    out_free;
   logic                    take;
   logic                    fin;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign take     = !drain_ff && in_valid_ff && out_free;

   assign req_ch.ready        = !in_valid_ff || take;
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_byte     = out_byte_ff;
   assign rsp_ch.out_line_end = out_end_ff;
   assign rsp_ch.last_of_run  = out_last_ff;

   assign status = '{draining: drain_ff, take: take, fill: st_ff.fill};

   // append the held byte to the window
   always_comb begin
      appended = st_ff;
      slot     = (st_ff.fill >= cb_pkg::FILL_W'(cb_pkg::MAX_MARKER))
                 ? cb_pkg::FILL_W'(cb_pkg::MAX_MARKER - 1) : st_ff.fill;
      appended.window[slot[cb_pkg::IDX_W-1:0]] = in_byte_ff;
      appended.fill = slot + 1'b1;
   end

   // one scan step on the drained or freshly appended window
   assign src = drain_ff ? st_ff : appended;
   assign em  = cb_pkg::emit_head(src, cfg, src.fill == cb_pkg::FILL_W'(1));
   assign fin = (em.st.fill == '0);

   // sequence the engine
   always_comb begin
      st_in        = st_ff;
      drain_in     = drain_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      if (drain_ff) begin
         if (out_free) begin
            st_in        = em.st;
            out_valid_in = 1'b1;
            out_byte_in  = em.out_byte;
            out_end_in   = fin;
            out_last_in  = fin;
            if (fin) begin
               drain_in              = 1'b0;
               st_in.in_line_comment = 1'b0;
               st_in.forced_bytes    = '0;
               st_in.prior_out       = '0;
            end
         end
      end else if (take) begin
         if (in_end_ff) begin
            st_in        = em.st;
            out_valid_in = 1'b1;
            out_byte_in  = em.out_byte;
            out_end_in   = fin;
            out_last_in  = fin;
            if (fin) begin
               st_in.in_line_comment = 1'b0;
               st_in.forced_bytes    = '0;
               st_in.prior_out       = '0;
            end else begin
               drain_in = 1'b1;
            end
         end else if (appended.fill == cb_pkg::FILL_W'(cb_pkg::MAX_MARKER)) begin
            st_in        = em.st;
            out_valid_in = 1'b1;
            out_byte_in  = em.out_byte;
            out_end_in   = 1'b0;
            out_last_in  = 1'b1;
         end else begin
            st_in = appended;
         end
      end
   end

   // hold or load the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         drain_ff              <= 1'b0;
         st_ff.fill            <= '0;
         st_ff.nest_depth      <= '0;
         st_ff.quote_mode      <= cb_pkg::QUOTE_NONE;
         st_ff.in_line_comment <= 1'b0;
         st_ff.forced_bytes    <= '0;
         st_ff.forced_blank    <= 1'b0;
         st_ff.prior_out       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         drain_ff     <= drain_in;
         st_ff        <= st_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.text_byte;
         in_end_ff  <= req_ch.line_end;
      end
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_last_ff <= out_last_in;
   end

endmodule

>>> design/comment_blanker.sv
`timescale 1ns / 1ps
// ============================================================================
// comment_blanker - streaming source comment blanker
// Returns source bytes in order with line and block comments turned into
// spaces, keeping tabs, line ends, quoted text and Shift-JIS pairs.
// ============================================================================
// Takes one byte per cycle while the scan engine is not draining and the
// result register is free. An item passes an input register and then the
// result register. Output lags input by up to three bytes inside a line;
// the byte marked as line end drains the lookahead window, and the scan
// engine then gives one result per buffered byte (one to four), since the
// result register takes one byte per cycle while the receiver accepts.
// Configure markers only while no line is in flight.
module comment_blanker (
   input  logic                          clock,
   input  logic                          reset,
   cb_req_if.sink                        req_ch,
   cb_rsp_if.source                      rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);

   cb_pkg::cfg_type         cfg;
   cb_pkg::core_status_type status;

   cb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .status (status)
   );

   // drain only runs while bytes remain in the window
   a_drain_has_bytes: assert property (@(posedge clock) disable iff (reset)
      status.draining |-> (status.fill != '0))
      else $error("drain with empty window");

   // window never rests full: a full window always emits its head
   a_window_not_full: assert property (@(posedge clock) disable iff (reset)
      status.fill != cb_pkg::FILL_W'(cb_pkg::MAX_MARKER))
      else $error("window left full");

   // no new item enters the engine during a drain
   a_no_take_in_drain: assert property (@(posedge clock) disable iff (reset)
      status.draining |-> !status.take)
      else $error("item taken during drain");

   // a line end result closes its run
   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_line_end) |-> rsp_ch.last_of_run)
      else $error("line end not last of run");

endmodule

>>> test/tb_comment_blanker.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_comment_blanker - self-checking bench for the comment blanker
// Streams source lines through the block under several marker settings. A
// scan model inside the bench predicts every output byte with its line-end
// and run-end marks, and each returned item is checked against the oldest
// prediction. A short table of hand-picked lines comes first. Random lines
// built from marker, quote, escape, tab and double-byte pieces follow, with
// random idling on both channels and one long receiver hold-off.
// ============================================================================
module tb_comment_blanker;

   // Characters used by the stimulus
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] SJIS_LO1 = 8'h81;
   localparam logic [7:0] SJIS_HI1 = 8'h9F;
   localparam logic [7:0] SJIS_LO2 = 8'hE0;
   localparam logic [7:0] SJIS_HI2 = 8'hFC;
   localparam int HOLD_CYCLES = 120;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_line_end;
      logic       last_of_run;
   } out_byte_type;

   // One row of the directed table: a register write or one source byte
   typedef struct packed {
      logic                  is_cfg;
      cb_pkg::reg_index_type idx;
      logic [31:0]           val;
      logic [7:0]            text;
      logic                  eol;
      logic                  known;
      logic [7:0]            exp;
   } dir_row_type;

   localparam int N_DIR = 34;
   dir_row_type dir_rows [0:N_DIR-1] = '{
      // right after reset nothing is a comment: extremes come back unchanged
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, 8'h00, 1'b1, 1'b1, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, 8'hFF, 1'b1, 1'b1, 8'hFF},
      // C style markers with quote tracking
      '{1'b1, cb_pkg::REG_LINE_MARKER,      32'h2F2F, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b1, cb_pkg::REG_LINE_MARKER_LEN,  32'h2,    8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b1, cb_pkg::REG_BEGIN_MARKER,     32'h2A2F, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b1, cb_pkg::REG_BEGIN_MARKER_LEN, 32'h2,    8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b1, cb_pkg::REG_END_MARKER,       32'h2F2A, 8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b1, cb_pkg::REG_END_MARKER_LEN,   32'h2,    8'h00, 1'b0, 1'b0, 8'h00},
      '{1'b1, cb_pkg::REG_TRACK_QUOTES,     32'h1,    8'h00, 1'b0, 1'b0, 8'h00},
      // block comment around a tab, closed on the same line
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH,       1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_STAR,        1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, cb_pkg::CH_TAB, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_STAR,        1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH,       1'b1, 1'b0, 8'h00},
      // line marker inside double quotes is kept
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, cb_pkg::CH_DQUOTE, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH,          1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH,          1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, cb_pkg::CH_DQUOTE, 1'b1, 1'b0, 8'h00},
      // escaped quote does not open a string, so the line comment starts
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, cb_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, cb_pkg::CH_SQUOTE, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH,          1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH,          1'b1, 1'b0, 8'h00},
      // double byte swallows a marker byte; a lead at the line end stays alone
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, SJIS_HI1, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_STAR,  1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, SJIS_HI2, 1'b1, 1'b1, SJIS_HI2},
      // open comment; lead at the line end is blanked alone
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_STAR,  1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, SJIS_LO2, 1'b1, 1'b1, cb_pkg::CH_SPACE},
      // nest one level deeper and close it again, comment stays open
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_STAR,  1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_STAR,  1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_SLASH, 1'b0, 1'b0, 8'h00},
      '{1'b0, cb_pkg::REG_LINE_MARKER, 32'h0, CH_X,     1'b1, 1'b0, 8'h00}
   };

   logic clock;
   logic reset;

   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [cb_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [cb_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [cb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                          csr_pready;

   cb_req_if req_ch ();
   cb_rsp_if rsp_ch ();

   comment_blanker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Scan model state and the register copy it works from
   cb_pkg::cfg_type        shadow       = '0;
   logic [7:0]             win [cb_pkg::MAX_MARKER];
   int unsigned            fill         = 0;
   logic [cb_pkg::NEST_BITS-1:0] depth  = '0;
   cb_pkg::quote_mode_type qmode        = cb_pkg::QUOTE_NONE;
   bit                     in_lc        = 1'b0;
   int unsigned            forced       = 0;
   bit                     forced_blank = 1'b0;
   logic [7:0]             prior        = 8'h00;

   out_byte_type awaited_bytes [$];
   logic [7:0]   line_buf [$];

   logic       tag_known = 1'b0;
   logic [7:0] tag_exp   = 8'h00;

   int errors         = 0;
   int bytes_in       = 0;
   int bytes_out      = 0;
   int reg_writes     = 0;
   int max_depth_seen = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   bit hold_request   = 1'b0;

   // Print one line per mismatch and count it
   task automatic report_mismatch(string what);
      errors++;
      $display("tb_comment_blanker: mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic int clamp_len(logic [cb_pkg::LEN_BITS-1:0] len);
      return (int'(len) > cb_pkg::MAX_MARKER) ? cb_pkg::MAX_MARKER : int'(len);
   endfunction

   function automatic bit lead_byte(logic [7:0] b);
      return ((b >= SJIS_LO1) && (b <= SJIS_HI1)) || ((b >= SJIS_LO2) && (b <= SJIS_HI2));
   endfunction

   // Whole marker present at the head of the window
   function automatic bit marker_at_head(logic [31:0] marker, int len);
      bit ok;
      ok = (len != 0) && (len <= int'(fill));
      for (int i = 0; i < len && i < cb_pkg::MAX_MARKER; i++) begin
         if (win[i] != marker[8*i +: 8]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // Blank or keep the head byte of the window, then shift the window
   function automatic logic [7:0] blank_head(bit last);
      logic [7:0] b;
      logic [7:0] o;
      int bl;
      int el;
      int ll;
      b  = win[0];
      o  = b;
      bl = clamp_len(shadow.begin_marker_len);
      el = clamp_len(shadow.end_marker_len);
      ll = clamp_len(shadow.line_marker_len);
      if (forced > 0) begin
         o = forced_blank ? cb_pkg::CH_SPACE : b;
         forced--;
      end else if (in_lc) begin
         o = (b == cb_pkg::CH_TAB) ? b : cb_pkg::CH_SPACE;
      end else if ((depth != '0) && (qmode == cb_pkg::QUOTE_NONE)) begin
         o = cb_pkg::CH_SPACE;
         if (lead_byte(b)) begin
            if (!last) begin
               forced       = 1;
               forced_blank = 1'b1;
            end
         end else if ((bl > 0) && marker_at_head(shadow.begin_marker, bl)) begin
            forced       = bl - 1;
            forced_blank = 1'b1;
            if (depth != cb_pkg::NEST_MAX) depth++;
         end else if ((bl > 0) && marker_at_head(shadow.end_marker, el)) begin
            forced       = el - 1;
            forced_blank = 1'b1;
            depth--;
         end else if (b == cb_pkg::CH_TAB) begin
            o = b;
         end
      end else if (lead_byte(b)) begin
         if (!last) begin
            forced       = 1;
            forced_blank = 1'b0;
         end
      end else if ((qmode == cb_pkg::QUOTE_NONE) && (bl > 0)
                   && marker_at_head(shadow.begin_marker, bl)) begin
         o            = cb_pkg::CH_SPACE;
         forced       = bl - 1;
         forced_blank = 1'b1;
         if (depth != cb_pkg::NEST_MAX) depth++;
      end else if ((qmode == cb_pkg::QUOTE_NONE)
                   && marker_at_head(shadow.line_marker, ll)) begin
         in_lc = 1'b1;
         o     = (b == cb_pkg::CH_TAB) ? b : cb_pkg::CH_SPACE;
      end else if (shadow.track_quotes && (prior != cb_pkg::CH_BSLASH)) begin
         // toggle the quote state on an unescaped quote
         if (b == cb_pkg::CH_SQUOTE) begin
            if (qmode == cb_pkg::QUOTE_NONE) qmode = cb_pkg::QUOTE_SINGLE;
            else if (qmode == cb_pkg::QUOTE_SINGLE) qmode = cb_pkg::QUOTE_NONE;
         end else if (b == cb_pkg::CH_DQUOTE) begin
            if (qmode == cb_pkg::QUOTE_NONE) qmode = cb_pkg::QUOTE_DOUBLE;
            else if (qmode == cb_pkg::QUOTE_DOUBLE) qmode = cb_pkg::QUOTE_NONE;
         end
      end
      prior = o;
      for (int i = 1; i < int'(fill); i++) begin
         win[i-1] = win[i];
      end
      if (fill > 0) fill--;
      return o;
   endfunction

   // Take one accepted source byte and queue the output bytes it releases
   function automatic void predict_text(logic [7:0] b, logic eol, logic known,
                                        logic [7:0] exp);
      out_byte_type r;
      int before_n;
      before_n  = awaited_bytes.size();
      win[fill] = b;
      fill++;
      if (eol) begin
         // drain the window at the line end
         while (fill > 0) begin
            r.out_byte     = blank_head(fill == 1);
            r.out_line_end = (fill == 0);
            r.last_of_run  = (fill == 0);
            awaited_bytes.push_back(r);
         end
         in_lc  = 1'b0;
         forced = 0;
         prior  = 8'h00;
      end else if (fill == cb_pkg::MAX_MARKER) begin
         r.out_byte     = blank_head(1'b0);
         r.out_line_end = 1'b0;
         r.last_of_run  = 1'b1;
         awaited_bytes.push_back(r);
      end
      // hand-typed value replaces the last prediction of this row
      if (known && (awaited_bytes.size() > before_n)) begin
         r          = awaited_bytes.pop_back();
         r.out_byte = exp;
         awaited_bytes.push_back(r);
      end
      if (int'(depth) > max_depth_seen) max_depth_seen = int'(depth);
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up after a generous fixed time
   initial begin
      #2000000;
      $display("tb_comment_blanker: timeout with %0d results outstanding",
               awaited_bytes.size());
      $display("tb_comment_blanker: FAIL");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int  hold_left;
      bit  go;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            go = 1'b0;
         end else begin
            go = ($urandom_range(0, 99) >= recv_idle_pct);
         end
         rsp_ch.ready <= go;
      end
   end

   // Predict on every accepted input item, check every accepted result item
   always @(posedge clock) begin
      out_byte_type got;
      out_byte_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            predict_text(req_ch.text_byte, req_ch.line_end, tag_known, tag_exp);
            bytes_in++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_byte, rsp_ch.out_line_end, rsp_ch.last_of_run};
            bytes_out++;
            if (awaited_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %02h", got.out_byte));
            end else begin
               want = awaited_bytes.pop_front();
               if (got.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                            got.out_byte, want.out_byte));
               if (got.out_line_end !== want.out_line_end)
                  report_mismatch($sformatf("out_line_end %b, wanted %b",
                                            got.out_line_end, want.out_line_end));
               if (got.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, wanted %b",
                                            got.last_of_run, want.last_of_run));
            end
         end
      end
   end

   // Offer one source byte, with a random gap first, and hold until taken
   task automatic send_byte(logic [7:0] b, logic eol, logic known, logic [7:0] exp);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.text_byte <= b;
      req_ch.line_end  <= eol;
      tag_known        <= known;
      tag_exp          <= exp;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid, wait for every awaited result, then let the block settle
   task automatic settle(int extra);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited_bytes.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // Write one register, update the copy, and read it back
   task automatic csr_write(cb_pkg::reg_index_type idx, logic [31:0] val);
      logic [31:0] mask;
      logic [31:0] seen;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= cb_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         cb_pkg::REG_LINE_MARKER: begin
            mask = 32'hFFFF_FFFF; shadow.line_marker = val;
         end
         cb_pkg::REG_LINE_MARKER_LEN: begin
            mask = 32'h7; shadow.line_marker_len = val[2:0];
         end
         cb_pkg::REG_BEGIN_MARKER: begin
            mask = 32'hFFFF_FFFF; shadow.begin_marker = val;
         end
         cb_pkg::REG_BEGIN_MARKER_LEN: begin
            mask = 32'h7; shadow.begin_marker_len = val[2:0];
         end
         cb_pkg::REG_END_MARKER: begin
            mask = 32'hFFFF_FFFF; shadow.end_marker = val;
         end
         cb_pkg::REG_END_MARKER_LEN: begin
            mask = 32'h7; shadow.end_marker_len = val[2:0];
         end
         default: begin
            mask = 32'h1; shadow.track_quotes = val[0];
         end
      endcase
      reg_writes++;
      // read back through the same port
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (seen !== (val & mask))
         report_mismatch($sformatf("register %s reads %h, wrote %h", idx.name(), seen, val));
   endtask

   // Append the bytes of a configured marker, or a stray byte when it is empty
   function automatic void add_marker(logic [31:0] marker,
                                      logic [cb_pkg::LEN_BITS-1:0] len);
      int k;
      k = clamp_len(len);
      if (k == 0) begin
         line_buf.push_back(8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < k; i++) begin
         line_buf.push_back(marker[8*i +: 8]);
      end
   endfunction

   // Build one source line from marker, quote, escape and filler pieces
   function automatic void build_line(int open_pct, int close_pct);
      int n;
      int r;
      line_buf.delete();
      n = $urandom_range(1, 8);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < open_pct) begin
            add_marker(shadow.begin_marker, shadow.begin_marker_len);
         end else if (r < open_pct + close_pct) begin
            add_marker(shadow.end_marker, shadow.end_marker_len);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 14)      add_marker(shadow.line_marker, shadow.line_marker_len);
            else if (r < 28) add_marker(shadow.begin_marker, shadow.begin_marker_len);
            else if (r < 42) add_marker(shadow.end_marker, shadow.end_marker_len);
            else if (r < 47) line_buf.push_back(shadow.begin_marker[7:0]);
            else if (r < 55) line_buf.push_back(cb_pkg::CH_SQUOTE);
            else if (r < 63) line_buf.push_back(cb_pkg::CH_DQUOTE);
            else if (r < 69) line_buf.push_back(cb_pkg::CH_BSLASH);
            else if (r < 75) line_buf.push_back(cb_pkg::CH_TAB);
            else if (r < 79) line_buf.push_back(8'($urandom_range(SJIS_LO1, SJIS_HI1)));
            else if (r < 83) line_buf.push_back(8'($urandom_range(SJIS_LO2, SJIS_HI2)));
            else if (r < 87) line_buf.push_back(8'h00);
            else if (r < 90) line_buf.push_back(8'hFF);
            else             line_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   // Program one marker setting and stream whole random lines through it
   task automatic run_setting(logic [31:0] lm, logic [2:0] lml, logic [31:0] bm,
                              logic [2:0] bml, logic [31:0] em, logic [2:0] eml,
                              logic tq, int budget, int open_pct, int close_pct);
      int sent;
      sent = 0;
      settle(8);
      csr_write(cb_pkg::REG_LINE_MARKER, lm);
      csr_write(cb_pkg::REG_LINE_MARKER_LEN, 32'(lml));
      csr_write(cb_pkg::REG_BEGIN_MARKER, bm);
      csr_write(cb_pkg::REG_BEGIN_MARKER_LEN, 32'(bml));
      csr_write(cb_pkg::REG_END_MARKER, em);
      csr_write(cb_pkg::REG_END_MARKER_LEN, 32'(eml));
      csr_write(cb_pkg::REG_TRACK_QUOTES, 32'(tq));
      while (sent < budget) begin
         build_line(open_pct, close_pct);
         foreach (line_buf[i]) begin
            send_byte(line_buf[i], i == line_buf.size() - 1, 1'b0, 8'h00);
            sent++;
         end
      end
   endtask

   // Main sequence
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.text_byte = 8'h00;
      req_ch.line_end  = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles less than the receiver
      send_idle_pct = 38;
      recv_idle_pct = 69;

      // directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            settle(8);
            csr_write(dir_rows[i].idx, dir_rows[i].val);
         end else begin
            send_byte(dir_rows[i].text, dir_rows[i].eol, dir_rows[i].known,
                      dir_rows[i].exp);
         end
      end

      // C style, then saturated long line marker of all ones with quotes off
      run_setting(32'h2F2F, 3'd2, 32'h2A2F, 3'd2, 32'h2F2A, 3'd2, 1'b1, 28, 0, 0);
      run_setting(32'hFFFF_FFFF, 3'd7, 32'h2A28, 3'd2, 32'h292A, 3'd2, 1'b0, 28, 0, 0);

      // receiver idles less than the sender
      send_idle_pct = 69;
      recv_idle_pct = 38;
      // empty closing marker, then block comments switched off while inside one
      run_setting(32'h23, 3'd1, 32'h7B, 3'd1, 32'h0, 3'd0, 1'b1, 20, 10, 0);
      run_setting(32'h2D2D, 3'd2, 32'h7B, 3'd0, 32'h0, 3'd0, 1'b1, 14, 0, 0);

      // no idling; the receiver holds off long enough to back up the input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle(8);
      hold_request  = 1'b1;
      run_setting(32'h0, 3'd4, 32'h2D2D_213C, 3'd4, 32'h3E2D2D, 3'd3, 1'b0, 28, 0, 20);
      // stack up nested openings, then unwind part of them
      run_setting(32'hFFFF_FFFF, 3'd0, 32'h28, 3'd1, 32'h29, 3'd1, 1'b1, 110, 95, 0);
      run_setting(32'hFFFF_FFFF, 3'd0, 32'h28, 3'd1, 32'h29, 3'd1, 1'b0, 28, 0, 60);

      settle(20);
      $display("tb_comment_blanker: %0d source bytes streamed, %0d output bytes checked",
               bytes_in, bytes_out);
      $display("tb_comment_blanker: %0d register writes, deepest nesting %0d",
               reg_writes, max_depth_seen);
      if (errors == 0) begin
         $display("tb_comment_blanker: PASS");
      end else begin
         $display("tb_comment_blanker: FAIL");
      end
      $finish;
   end

endmodule
